/* src/wsjs_pkg.sv */
package wsjs_pkg;

  localparam int WORKER_COUNT = 4;
  localparam int DEQUE_DEPTH = 32;

  localparam int WORKER_W = $clog2(WORKER_COUNT);
  localparam int SLOT_W   = $clog2(DEQUE_DEPTH);
  localparam int IDX_W    = SLOT_W + 1;
  localparam int RING     = 2 * DEQUE_DEPTH;
  localparam int ADDR_W   = WORKER_W + SLOT_W;
  localparam int STORE_DEPTH = WORKER_COUNT * DEQUE_DEPTH;

  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 3;
  localparam int WORD_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  localparam logic [63:0] RNG_MULT = 64'h2545_F491_4F6C_DD1D;
  localparam int RNG_SH_A = 12;
  localparam int RNG_SH_B = 25;
  localparam int RNG_SH_C = 27;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_JOB   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_CNT = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] fn;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] off;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] v);
    logic [IDX_W:0] s;
    s = {1'b0, v} + (IDX_W+1)'(1);
    return (s >= (IDX_W+1)'(RING)) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] v);
    return (v == '0) ? IDX_W'(RING - 1) : v - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] occupancy(input logic [IDX_W-1:0] t,
                                                 input logic [IDX_W-1:0] h);
    logic [IDX_W:0] s;
    s = (IDX_W+1)'(RING) + {1'b0, t} - {1'b0, h};
    return (t >= h) ? (t - h) : s[IDX_W-1:0];
  endfunction

endpackage

/* src/wsjs_ram.sv */
module wsjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/work_stealing_job_scheduler.sv */
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_op, in_worker, in_job_*, in_invocation_count,
//                                            in_first_invocation
// out      output     out_valid / out_stall  out_status, out_function, out_data, out_count,
//                                            out_offset
// cfg      input      cfg_valid / cfg_ready  cfg_workers_in_use
//
// one item at a time; a local get adds a ram read wait, a split adds a halving step and the
// pushback, a steal adds xorshift, three passes of the shared 32x32 multiplier and the victim
// pick before the victim probe.
// jobs sit in one 128-bit wide synchronous ram, at most one job read per item, registered read data.
// synchronous active-low reset clears head/tail pointers and seeds generators; ram not cleared.
// a stalled result sits in the output register while the next item is taken in.
module work_stealing_job_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wsjs_pkg::OP_W-1:0]     in_op,
  input  logic [1:0]                    in_worker,
  input  logic [wsjs_pkg::WORD_W-1:0]   in_job_function,
  input  logic [wsjs_pkg::WORD_W-1:0]   in_job_data,
  input  logic [wsjs_pkg::WORD_W-1:0]   in_invocation_count,
  input  logic [wsjs_pkg::WORD_W-1:0]   in_first_invocation,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wsjs_pkg::STAT_W-1:0]   out_status,
  output logic [wsjs_pkg::WORD_W-1:0]   out_function,
  output logic [wsjs_pkg::WORD_W-1:0]   out_data,
  output logic [wsjs_pkg::WORD_W-1:0]   out_count,
  output logic [wsjs_pkg::WORD_W-1:0]   out_offset,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsjs_pkg::CFG_W-1:0]    cfg_workers_in_use
);
  import wsjs_pkg::*;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] S_DECODE = 4'd1;
  localparam logic [STATE_W-1:0] S_RDWAIT = 4'd2;
  localparam logic [STATE_W-1:0] S_HALF   = 4'd3;
  localparam logic [STATE_W-1:0] S_SPLIT  = 4'd4;
  localparam logic [STATE_W-1:0] S_RNG    = 4'd5;
  localparam logic [STATE_W-1:0] S_MUL0   = 4'd6;
  localparam logic [STATE_W-1:0] S_MUL1   = 4'd7;
  localparam logic [STATE_W-1:0] S_MUL2   = 4'd8;
  localparam logic [STATE_W-1:0] S_PICK   = 4'd9;
  localparam logic [STATE_W-1:0] S_VICT   = 4'd10;
  localparam logic [STATE_W-1:0] S_OUT    = 4'd11;

  localparam int PICK_W = WORD_W + CFG_W;

  // control state
  logic [STATE_W-1:0]  state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    head_r [WORKER_COUNT];
  logic [IDX_W-1:0]    head_nxt [WORKER_COUNT];
  logic [IDX_W-1:0]    tail_r [WORKER_COUNT];
  logic [IDX_W-1:0]    tail_nxt [WORKER_COUNT];
  logic [63:0]         rng_r [WORKER_COUNT];
  logic [63:0]         rng_nxt [WORKER_COUNT];
  logic [CFG_W-1:0]    cfg_r;

  // item payload and working registers
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [WORKER_W-1:0] w_r, w_nxt;
  logic [WORKER_W-1:0] v_r, v_nxt;
  job_t                in_job_r, in_job_nxt;
  job_t                res_r, res_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic                split_r, split_nxt;
  logic [WORD_W-1:0]   half_r, half_nxt;
  logic [WORD_W-1:0]   first_r, first_nxt;
  logic [63:0]         x_r, x_nxt;
  logic [63:0]         acc_r, acc_nxt;
  job_t                out_r, out_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  // ram ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  job_t                ram_wdata;
  logic [JOB_W-1:0]    ram_rdata;
  job_t                rd_job;

  // shared multiplier
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [2*WORD_W-1:0] mul_p;

  logic [WORKER_W-1:0] idx;
  logic [IDX_W-1:0]    tail_cur, head_cur, occ_cur, tail_dec;
  logic [63:0]         rng_cur;
  logic [63:0]         xs;
  logic [CFG_W-1:0]    n_clamp;
  logic [PICK_W-1:0]   pick_prod;
  logic [CFG_W-1:0]    pick_r, pick_v;

  wsjs_ram #(
    .WIDTH (JOB_W),
    .DEPTH (STORE_DEPTH)
  ) u_job_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_job = job_t'(ram_rdata);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_function = out_r.fn;
  assign out_data     = out_r.data;
  assign out_count    = out_r.cnt;
  assign out_offset   = out_r.off;

  // pointer lookups go to the victim only while probing it
  assign idx      = (state_r == S_VICT) ? v_r : w_r;
  assign tail_cur = tail_r[idx];
  assign head_cur = head_r[idx];
  assign rng_cur  = rng_r[idx];
  assign occ_cur  = occupancy(tail_cur, head_cur);
  assign tail_dec = ring_dec(tail_cur);

  always_comb begin
    xs = rng_cur;
    xs = xs ^ (xs >> RNG_SH_A);
    xs = xs ^ (xs << RNG_SH_B);
    xs = xs ^ (xs >> RNG_SH_C);
  end

  // low 64 bits of x * mult built from three 32x32 partial products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL0: begin
        mul_a = x_r[31:0];
        mul_b = RNG_MULT[31:0];
      end
      S_MUL1: begin
        mul_a = x_r[31:0];
        mul_b = RNG_MULT[63:32];
      end
      S_MUL2: begin
        mul_a = x_r[63:32];
        mul_b = RNG_MULT[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (cfg_r < CFG_W'(2)) begin
      n_clamp = CFG_W'(2);
    end else if (cfg_r > CFG_W'(WORKER_COUNT)) begin
      n_clamp = CFG_W'(WORKER_COUNT);
    end else begin
      n_clamp = cfg_r;
    end
  end

  // victim draw: scale the high word into 0..n-2, then step over self
  assign pick_prod = PICK_W'(acc_r[63:32]) * PICK_W'(n_clamp - CFG_W'(1));
  assign pick_r    = pick_prod[PICK_W-1:WORD_W];
  assign pick_v    = (pick_r >= CFG_W'(w_r)) ? pick_r + CFG_W'(1) : pick_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    rng_nxt        = rng_r;
    op_nxt         = op_r;
    w_nxt          = w_r;
    v_nxt          = v_r;
    in_job_nxt     = in_job_r;
    res_nxt        = res_r;
    res_status_nxt = res_status_r;
    split_nxt      = split_r;
    half_nxt       = half_r;
    first_nxt      = first_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    out_nxt        = out_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_op;
          w_nxt           = in_worker[WORKER_W-1:0];
          in_job_nxt.fn   = in_job_function;
          in_job_nxt.data = in_job_data;
          in_job_nxt.cnt  = in_invocation_count;
          in_job_nxt.off  = in_first_invocation;
          state_nxt       = S_DECODE;
        end
      end

      S_DECODE: begin
        res_nxt        = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_OUT;
        unique case (op_r)
          OP_PUSH: begin
            if (in_job_r.cnt == '0) begin
              res_status_nxt = ST_ZERO_CNT;
            end else if (occ_cur >= IDX_W'(DEQUE_DEPTH)) begin
              res_status_nxt = ST_OVERFLOW;
            end else begin
              ram_we        = 1'b1;
              ram_waddr     = {w_r, tail_cur[SLOT_W-1:0]};
              ram_wdata     = in_job_r;
              tail_nxt[w_r] = ring_inc(tail_cur);
            end
          end
          OP_GET: begin
            if (occ_cur == '0) begin
              state_nxt = S_RNG;
            end else begin
              // newest local job; the last one left is split
              tail_nxt[w_r] = tail_dec;
              ram_raddr     = {w_r, tail_dec[SLOT_W-1:0]};
              split_nxt     = (occ_cur == IDX_W'(1));
              if (occ_cur == IDX_W'(1)) begin
                head_nxt[w_r] = tail_dec;
              end
              state_nxt = S_RDWAIT;
            end
          end
          OP_CHECK: begin
            if (in_job_r.cnt == '0) begin
              res_status_nxt = ST_ZERO_CNT;
            end else begin
              res_nxt = in_job_r;
              if (occ_cur == '0) begin
                state_nxt = S_HALF;
              end
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end

      S_RDWAIT: begin
        res_nxt   = rd_job;
        state_nxt = split_r ? S_HALF : S_OUT;
      end

      S_HALF: begin
        half_nxt  = res_r.cnt >> 1;
        first_nxt = (res_r.cnt >> 1) + WORD_W'(res_r.cnt[0]);
        state_nxt = S_SPLIT;
      end

      S_SPLIT: begin
        // second half goes back on the local deque, which is empty here
        if (half_r != '0) begin
          ram_we         = 1'b1;
          ram_waddr      = {w_r, tail_cur[SLOT_W-1:0]};
          ram_wdata.fn   = res_r.fn;
          ram_wdata.data = res_r.data;
          ram_wdata.cnt  = half_r;
          ram_wdata.off  = res_r.off + first_r;
          tail_nxt[w_r]  = ring_inc(tail_cur);
        end
        res_nxt.cnt = first_r;
        state_nxt   = S_OUT;
      end

      S_RNG: begin
        x_nxt     = xs;
        state_nxt = S_MUL0;
      end

      S_MUL0: begin
        acc_nxt   = mul_p;
        state_nxt = S_MUL1;
      end

      S_MUL1: begin
        acc_nxt[63:32] = acc_r[63:32] + mul_p[31:0];
        state_nxt      = S_MUL2;
      end

      S_MUL2: begin
        acc_nxt[63:32] = acc_r[63:32] + mul_p[31:0];
        state_nxt      = S_PICK;
      end

      S_PICK: begin
        rng_nxt[w_r] = acc_r;
        v_nxt        = pick_v[WORKER_W-1:0];
        state_nxt    = S_VICT;
      end

      S_VICT: begin
        if (occ_cur == '0) begin
          res_nxt        = '0;
          res_status_nxt = ST_NO_JOB;
          state_nxt      = S_OUT;
        end else begin
          // steal the oldest job of the victim
          ram_raddr     = {v_r, head_cur[SLOT_W-1:0]};
          head_nxt[v_r] = ring_inc(head_cur);
          split_nxt     = 1'b1;
          state_nxt     = S_RDWAIT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt        = res_r;
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= CFG_RESET;
      for (int i = 0; i < WORKER_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        rng_r[i]  <= 64'(i + 1);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      rng_r       <= rng_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_workers_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    w_r          <= w_nxt;
    v_r          <= v_nxt;
    in_job_r     <= in_job_nxt;
    res_r        <= res_nxt;
    res_status_r <= res_status_nxt;
    split_r      <= split_nxt;
    half_r       <= half_nxt;
    first_r      <= first_nxt;
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    out_r        <= out_nxt;
    out_status_r <= out_status_nxt;
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");

  a_victim_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VICT) |-> (v_r != w_r))
    else $error("victim equals issuing worker");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE) |-> (occ_cur <= IDX_W'(DEQUE_DEPTH)))
    else $error("deque occupancy beyond depth");

  a_split_local_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (occupancy(tail_r[w_r], head_r[w_r]) == '0))
    else $error("split push onto non-empty deque");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || !out_stall)) |=> (out_valid && state_r == S_IDLE))
    else $error("result not presented");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import wsjs_pkg::*;

  // op 3 has no name in the package; the block takes it and answers with an all-zero ST_OK result
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] fn;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] off;
  } job_grant_t;

  class deque_scoreboard;
    job_t             store [WORKER_COUNT][DEQUE_DEPTH];
    logic [IDX_W-1:0] head [WORKER_COUNT];
    logic [IDX_W-1:0] tail [WORKER_COUNT];
    logic [63:0]      rng [WORKER_COUNT];
    logic [CFG_W-1:0] workers_in_use;
    job_grant_t       pending_grants [$];
    int               mismatches;

    function new();
      for (int i = 0; i < WORKER_COUNT; i++) begin
        head[i] = '0;
        tail[i] = '0;
        rng[i]  = 64'(i + 1);
      end
      workers_in_use = CFG_RESET;
      mismatches = 0;
    endfunction

    // head and tail count modulo 2*DEQUE_DEPTH, which is exactly the counter range
    function logic [IDX_W-1:0] jobs_held(int w);
      return tail[w] - head[w];
    endfunction

    function logic [STAT_W-1:0] append_job(int w, job_t j);
      if (jobs_held(w) >= IDX_W'(DEQUE_DEPTH)) return ST_OVERFLOW;
      store[w][tail[w][SLOT_W-1:0]] = j;
      tail[w] = tail[w] + 1'b1;
      return ST_OK;
    endfunction

    // grant the first half now, hand the second half back to the local deque
    function logic [WORD_W-1:0] halve_job(int w, job_t j);
      logic [WORD_W-1:0] rest;
      logic [WORD_W-1:0] now_cnt;
      job_t back;
      rest = j.cnt >> 1;
      now_cnt = j.cnt - rest;
      if (rest != '0) begin
        back = j;
        back.cnt = rest;
        back.off = j.off + now_cnt;
        void'(append_job(w, back));
      end
      return now_cnt;
    endfunction

    function int draw_victim(int w);
      logic [63:0] x;
      logic [63:0] prod;
      logic [WORD_W-1:0] r;
      int n;
      if (workers_in_use < 2) n = 2;
      else if (workers_in_use > WORKER_COUNT) n = WORKER_COUNT;
      else n = int'(workers_in_use);
      x = rng[w];
      x ^= x >> RNG_SH_A;
      x ^= x << RNG_SH_B;
      x ^= x >> RNG_SH_C;
      x = x * RNG_MULT;
      rng[w] = x;
      prod = {32'd0, x[63:32]} * 64'(n - 1);
      r = prod[63:32];
      // skip the requesting worker
      if (r >= w) r = r + 1;
      return int'(r % WORKER_COUNT);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [1:0] worker, job_t j);
      job_grant_t g;
      job_t got;
      logic [IDX_W-1:0] held;
      logic granted;
      int w;
      int v;
      g = '0;
      w = worker % WORKER_COUNT;
      case (op)
        OP_PUSH: begin
          if (j.cnt == '0) g.status = ST_ZERO_CNT;
          else g.status = append_job(w, j);
        end
        OP_GET: begin
          granted = 1'b1;
          held = jobs_held(w);
          if (held != '0) begin
            tail[w] = tail[w] - 1'b1;
            got = store[w][tail[w][SLOT_W-1:0]];
            if (held == 1) begin
              head[w] = tail[w];
              got.cnt = halve_job(w, got);
            end
          end else begin
            v = draw_victim(w);
            if (jobs_held(v) == '0) begin
              g.status = ST_NO_JOB;
              granted = 1'b0;
            end else begin
              got = store[v][head[v][SLOT_W-1:0]];
              head[v] = head[v] + 1'b1;
              got.cnt = halve_job(w, got);
            end
          end
          if (granted) begin
            g.fn   = got.fn;
            g.data = got.data;
            g.cnt  = got.cnt;
            g.off  = got.off;
          end
        end
        OP_CHECK: begin
          if (j.cnt == '0) begin
            g.status = ST_ZERO_CNT;
          end else begin
            g.fn   = j.fn;
            g.data = j.data;
            g.off  = j.off;
            if (jobs_held(w) != '0) g.cnt = j.cnt;
            else g.cnt = halve_job(w, j);
          end
        end
        default: ;
      endcase
      pending_grants.push_back(g);
    endfunction

    function void compare_field(string label, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(job_grant_t seen);
      job_grant_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d count %h",
                 $time, seen.status, seen.cnt);
        mismatches++;
        return;
      end
      want = pending_grants.pop_front();
      compare_field("status", WORD_W'(want.status), WORD_W'(seen.status));
      compare_field("function", want.fn, seen.fn);
      compare_field("data", want.data, seen.data);
      compare_field("count", want.cnt, seen.cnt);
      compare_field("offset", want.off, seen.off);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = OP_PUSH;
  logic [1:0]        in_worker = '0;
  logic [WORD_W-1:0] in_job_function = '0;
  logic [WORD_W-1:0] in_job_data = '0;
  logic [WORD_W-1:0] in_invocation_count = '0;
  logic [WORD_W-1:0] in_first_invocation = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [WORD_W-1:0] out_function;
  logic [WORD_W-1:0] out_data;
  logic [WORD_W-1:0] out_count;
  logic [WORD_W-1:0] out_offset;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_workers_in_use = CFG_RESET;

  // no random gaps on either side while set
  bit steady = 1'b0;

  deque_scoreboard deques = new();

  work_stealing_job_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_worker           (in_worker),
    .in_job_function     (in_job_function),
    .in_job_data         (in_job_data),
    .in_invocation_count (in_invocation_count),
    .in_first_invocation (in_first_invocation),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_function        (out_function),
    .out_data            (out_data),
    .out_count           (out_count),
    .out_offset          (out_offset),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_workers_in_use  (cfg_workers_in_use)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0)
      deques.note_request(in_op, in_worker, {in_job_function, in_job_data,
                                             in_invocation_count, in_first_invocation});
    if (rst_n && out_valid === 1'b1 && !out_stall)
      deques.check_result({out_status, out_function, out_data, out_count, out_offset});
  end

  initial begin : result_backpressure
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid === 1'b1 && !out_stall));
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [1:0] worker,
                              input logic [WORD_W-1:0] fn, input logic [WORD_W-1:0] data,
                              input logic [WORD_W-1:0] cnt, input logic [WORD_W-1:0] off);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_op               <= op;
    in_worker           <= worker;
    in_job_function     <= fn;
    in_job_data         <= data;
    in_invocation_count <= cnt;
    in_first_invocation <= off;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_random(input int push_pct);
    int pick;
    logic [OP_W-1:0] op;
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] off;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) op = OP_PUSH;
    else if (pick < 97) op = ($urandom_range(0, 2) == 0) ? OP_CHECK : OP_GET;
    else op = OP_NONE;
    case ($urandom_range(0, 15))
      0:       cnt = '0;
      1:       cnt = 32'hFFFF_FFFF;
      2, 3:    cnt = $urandom();
      default: cnt = $urandom_range(1, 9);
    endcase
    // offsets near the top so the second half wraps
    if ($urandom_range(0, 3) == 0) off = 32'hFFFF_FFFF - $urandom_range(0, 15);
    else off = $urandom();
    send_request(op, 2'($urandom_range(0, 3)), $urandom(), $urandom(), cnt, off);
  endtask

  // hold off the sender until every expected result has been transferred out
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (deques.pending_grants.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_worker_pool(input logic [CFG_W-1:0] n);
    cfg_valid          <= 1'b1;
    cfg_workers_in_use <= n;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    deques.workers_in_use = n;
  endtask

  initial begin
    logic [CFG_W-1:0] pool_plan [10];
    int push_pct;
    pool_plan = '{3'd2, 3'd7, 3'd3, 3'd0, 3'd4,
                  3'd5, 3'd1, 3'd6, 3'd2, 3'd4};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_worker_pool(3'd4);

    send_request(OP_GET, 2'd0, 32'h1111_1111, 32'h2222_2222, 32'd5, 32'd0);
    send_request(OP_PUSH, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_NONE, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_PUSH, 2'd1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_PUSH, 2'd1, 32'h0, 32'hFFFF_FFFF, 32'd1, 32'h0);
    // two jobs held: newest comes back whole
    send_request(OP_GET, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    // last local job: split, second half wraps past the top offset
    send_request(OP_GET, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_request(OP_GET, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_request(OP_CHECK, 2'd2, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd9, 32'd100);
    send_request(OP_CHECK, 2'd2, 32'h0123_4567, 32'h89AB_CDEF, 32'd6, 32'd7);
    // a count of one is granted whole with nothing pushed back
    send_request(OP_PUSH, 2'd3, 32'hCAFE_0001, 32'hCAFE_0002, 32'd1, 32'd42);
    send_request(OP_GET, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
    // empty local deques: steal from a victim
    send_request(OP_GET, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
    repeat (3) send_request(OP_GET, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    repeat (2) send_request(OP_GET, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0);
    wait_for_idle();

    for (int p = 0; p < 10; p++) begin
      set_worker_pool(pool_plan[p]);
      steady = (p == 3 || p == 7);
      if (p == 0) begin
        // fill one deque past its depth
        for (int i = 0; i < DEQUE_DEPTH + 2; i++)
          send_request(OP_PUSH, 2'd0, $urandom(), $urandom(), 32'(i + 1), 32'(i));
        repeat (2) send_request(OP_GET, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      end
      push_pct = (p % 3 == 0) ? 60 : (p % 3 == 1) ? 30 : 45;
      repeat (115) send_random(push_pct);
      wait_for_idle();
    end

    if (deques.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
